[design/srtfq_pkg.sv]
// Shared types, codes and field widths for the SRTF ready queue.
package srtfq_pkg;

    // Default configuration
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 8;

    // Fixed field widths on the stream ports
    localparam int PROC_ID_W   = 8;
    localparam int TIME_W      = 20;
    localparam int CNT_OUT_W   = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_PICK   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_UPDATE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ROTATE,
        ST_PLACE,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]    remaining_time;
        logic [PROC_ID_W-1:0] proc_id;
        action_t              action;
    } cmd_t;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] queue_count;
        logic [CNT_OUT_W-1:0] expired_count;
        logic [PROC_ID_W-1:0] chosen_id;
        logic                 chosen_valid;
        logic                 accepted;
    } res_t;

endpackage

[design/srtfq_engine.sv]
// Ready list storage and the sweep sequencer that adds, picks, removes and updates entries.
module srtfq_engine #(
    parameter int QUEUE_DEPTH = srtfq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = srtfq_pkg::DEF_ID_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  srtfq_pkg::cmd_t  cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output srtfq_pkg::res_t  res
);

    localparam int TW      = srtfq_pkg::TIME_W;
    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_WIDTH + TW;
    localparam int IXW     = (ID_WIDTH > srtfq_pkg::PROC_ID_W) ? ID_WIDTH : srtfq_pkg::PROC_ID_W;
    localparam int XW      = (CW > srtfq_pkg::CNT_OUT_W) ? CW : srtfq_pkg::CNT_OUT_W;

    // Entry memory: {id, time} per slot, one read and one write port
    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    srtfq_pkg::state_t  state_reg, state_next;
    srtfq_pkg::action_t act_reg, act_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [TW-1:0]       time_reg, time_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic [CW-1:0]       wr_idx_reg, wr_idx_next;
    logic [AW-1:0]       rpos_reg, rpos_next;
    logic                dv_reg, dv_next;
    logic                more_reg, more_next;
    logic                found_reg, found_next;
    logic                acc_reg, acc_next;
    logic [CW-1:0]       expired_reg, expired_next;
    logic                have_best_reg, have_best_next;
    logic [AW-1:0]       best_pos_reg, best_pos_next;
    logic [ID_WIDTH-1:0] best_id_reg, best_id_next;
    logic [TW-1:0]       best_time_reg, best_time_next;

    logic [IXW-1:0]      cmd_id_x;
    logic [ID_WIDTH-1:0] cmd_id;
    logic [ID_WIDTH-1:0] ent_id;
    logic [TW-1:0]       ent_time;
    logic                match;
    logic [IXW-1:0]      best_id_x;
    logic [XW-1:0]       count_x;
    logic [XW-1:0]       expired_x;

    // Take the id in its low ID_WIDTH bits
    assign cmd_id_x = IXW'(cmd.proc_id);
    assign cmd_id   = cmd_id_x[ID_WIDTH-1:0];
    assign ent_id   = rd_data_reg[ENTRY_W-1:TW];
    assign ent_time = rd_data_reg[TW-1:0];
    assign match    = (ent_id == id_reg) && !found_reg;

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Sequencer: compaction sweep, backward rotate, place selected entry
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        time_next      = time_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        rpos_next      = rpos_reg;
        dv_next        = 1'b0;
        more_next      = more_reg;
        found_next     = found_reg;
        acc_next       = acc_reg;
        expired_next   = expired_reg;
        have_best_next = have_best_reg;
        best_pos_next  = best_pos_reg;
        best_id_next   = best_id_reg;
        best_time_next = best_time_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        cmd_ready      = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            srtfq_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    act_next       = cmd.action;
                    id_next        = cmd_id;
                    time_next      = cmd.remaining_time;
                    acc_next       = 1'b0;
                    expired_next   = '0;
                    have_best_next = 1'b0;
                    found_next     = 1'b0;
                    more_next      = 1'b0;
                    rd_idx_next    = '0;
                    wr_idx_next    = '0;
                    if (cmd.action == srtfq_pkg::ACT_ADD)
                    begin
                        // Append at the back, or reject as expired or full
                        state_next = srtfq_pkg::ST_REPLY;
                        if (cmd.remaining_time == '0)
                        begin
                            expired_next = CW'(1);
                        end
                        else if (count_reg < CW'(QUEUE_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = {cmd_id, cmd.remaining_time};
                            count_next = count_reg + CW'(1);
                            acc_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = srtfq_pkg::ST_SWEEP;
                    end
                end
            end

            srtfq_pkg::ST_SWEEP:
            begin
                // Handle the entry read last cycle
                if (dv_reg)
                begin
                    case (act_reg)
                        srtfq_pkg::ACT_PICK:
                        begin
                            if (ent_time == '0)
                            begin
                                expired_next = expired_reg + CW'(1);
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = wr_idx_reg[AW-1:0];
                                wr_data     = rd_data_reg;
                                wr_idx_next = wr_idx_reg + CW'(1);
                                if (!have_best_reg || (ent_time < best_time_reg))
                                begin
                                    have_best_next = 1'b1;
                                    best_pos_next  = wr_idx_reg[AW-1:0];
                                    best_id_next   = ent_id;
                                    best_time_next = ent_time;
                                end
                            end
                        end
                        srtfq_pkg::ACT_REMOVE:
                        begin
                            if (match)
                            begin
                                found_next = 1'b1;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = wr_idx_reg[AW-1:0];
                                wr_data     = rd_data_reg;
                                wr_idx_next = wr_idx_reg + CW'(1);
                            end
                        end
                        srtfq_pkg::ACT_UPDATE:
                        begin
                            if (match)
                            begin
                                found_next = 1'b1;
                                wr_en      = 1'b1;
                                wr_addr    = wr_idx_reg[AW-1:0];
                                wr_data    = {ent_id, time_reg};
                            end
                            wr_idx_next = wr_idx_reg + CW'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // Issue the next read, or close the sweep
                if (rd_idx_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + CW'(1);
                    dv_next     = 1'b1;
                end
                else
                begin
                    count_next = wr_idx_next;
                    acc_next   = found_next;
                    if ((act_reg == srtfq_pkg::ACT_PICK) && have_best_next &&
                        (best_pos_next != '0))
                    begin
                        state_next  = srtfq_pkg::ST_ROTATE;
                        rd_idx_next = CW'(best_pos_next) - CW'(1);
                        more_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = srtfq_pkg::ST_REPLY;
                    end
                end
            end

            srtfq_pkg::ST_ROTATE:
            begin
                // Shift entries ahead of the selected one back by one slot
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rpos_reg + AW'(1);
                    wr_data = rd_data_reg;
                end
                if (more_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = rd_idx_reg[AW-1:0];
                    rpos_next = rd_idx_reg[AW-1:0];
                    dv_next   = 1'b1;
                    if (rd_idx_reg == '0)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - CW'(1);
                    end
                end
                else
                begin
                    state_next = srtfq_pkg::ST_PLACE;
                end
            end

            srtfq_pkg::ST_PLACE:
            begin
                // Put the selected entry at the front
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {best_id_reg, best_time_reg};
                state_next = srtfq_pkg::ST_REPLY;
            end

            srtfq_pkg::ST_REPLY:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = srtfq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = srtfq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srtfq_pkg::ST_IDLE;
            count_reg     <= '0;
            dv_reg        <= 1'b0;
            more_reg      <= 1'b0;
            found_reg     <= 1'b0;
            acc_reg       <= 1'b0;
            expired_reg   <= '0;
            have_best_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dv_reg        <= dv_next;
            more_reg      <= more_next;
            found_reg     <= found_next;
            acc_reg       <= acc_next;
            expired_reg   <= expired_next;
            have_best_reg <= have_best_next;
        end
    end

    // Payload and pointer registers
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        id_reg        <= id_next;
        time_reg      <= time_next;
        rd_idx_reg    <= rd_idx_next;
        wr_idx_reg    <= wr_idx_next;
        rpos_reg      <= rpos_next;
        best_pos_reg  <= best_pos_next;
        best_id_reg   <= best_id_next;
        best_time_reg <= best_time_next;
    end

    // Assemble the result
    assign best_id_x = IXW'(best_id_reg);
    assign count_x   = XW'(count_reg);
    assign expired_x = XW'(expired_reg);

    always_comb
    begin
        res.accepted      = acc_reg;
        res.chosen_valid  = have_best_reg;
        res.chosen_id     = have_best_reg ? best_id_x[srtfq_pkg::PROC_ID_W-1:0] : '0;
        res.expired_count = expired_x[srtfq_pkg::CNT_OUT_W-1:0];
        res.queue_count   = count_x[srtfq_pkg::CNT_OUT_W-1:0];
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same slot in one cycle");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srtfq_pkg::ST_SWEEP) |-> (wr_idx_reg <= rd_idx_reg))
        else $error("compaction write pointer ran ahead of the reads");

    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srtfq_pkg::ST_IDLE && cmd_valid && cmd.action == srtfq_pkg::ACT_ADD)
        |=> (count_reg == $past(count_reg) + CW'(acc_reg)))
        else $error("add changed the count inconsistently with its result");

    a_rotate_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srtfq_pkg::ST_ROTATE) |-> (have_best_reg && best_pos_reg != '0))
        else $error("rotate pass without a selected entry");

endmodule

[design/srtf_ready_queue.sv]
// SRTF ready queue top level: stream ports, output register and the list engine.
// Steps: add writes its entry and goes straight to the reply; remove, update and pick
// sweep the N entries held; pick then rotates and places when B > 0; B the
// slot of the selected entry once expired entries are dropped.
// Throughput: one item at a time; the next input transfer is taken only after the result
// has moved into the output register; the one-slot-a-cycle sweep sets the item spacing.
// Reset: the list comes up empty at once; slots are not cleared, no clearing pass.
module srtf_ready_queue #(
    parameter int QUEUE_DEPTH = srtfq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = srtfq_pkg::DEF_ID_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // action [1:0], proc_id [9:2], remaining_time [29:10], zero [31:30]
    input  logic [srtfq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // accepted [0], chosen_valid [1], chosen_id [9:2], expired_count [14:10],
    // queue_count [19:15], zero [23:20]
    output logic [srtfq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    srtfq_pkg::cmd_t cmd;
    srtfq_pkg::res_t res;
    logic            res_valid;
    logic            res_ready;
    logic            m_valid_reg;
    logic [srtfq_pkg::OUT_TDATA_W-1:0] m_data_reg;

    // Unpack the input transfer
    assign cmd.action         = srtfq_pkg::action_t'(s_axis_tdata[1:0]);
    assign cmd.proc_id        = s_axis_tdata[9:2];
    assign cmd.remaining_time = s_axis_tdata[29:10];

    srtfq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= srtfq_pkg::OUT_TDATA_W'(res);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[sim/srtf_ready_queue_test.sv]
// Self-checking testbench for the SRTF ready queue: random and directed list traffic.
module srtf_ready_queue_test;

    localparam int DEPTH       = srtfq_pkg::DEF_QUEUE_DEPTH;
    localparam int ID_W        = srtfq_pkg::PROC_ID_W;
    localparam int T_W         = srtfq_pkg::TIME_W;
    localparam int CNT_W       = srtfq_pkg::CNT_OUT_W;
    localparam int IN_W        = srtfq_pkg::IN_TDATA_W;
    localparam int OUT_W       = srtfq_pkg::OUT_TDATA_W;
    localparam int CMD_W       = $bits(srtfq_pkg::cmd_t);
    localparam int RES_W       = $bits(srtfq_pkg::res_t);
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_ITEMS = 950;
    localparam int LONG_HOLD   = 300;

    // Ready-list predictor: mirrors the entry order and forecasts each reply
    class ready_list_model;
        logic [ID_W-1:0]     slot_ids [DEPTH];
        logic [T_W-1:0]      slot_times [DEPTH];
        int                  held;
        srtfq_pkg::res_t     pending_replies [$];
        int                  errors;
        int                  replies_checked;
        int                  picks_made;
        int                  expired_seen;
        int                  full_rejects;

        function new();
            held = 0;
            errors = 0;
            replies_checked = 0;
            picks_made = 0;
            expired_seen = 0;
            full_rejects = 0;
        endfunction

        // Close the gap left by a removed entry
        function void drop_at(int pos);
            int i;
            for (i = pos; i + 1 < held; i++)
            begin
                slot_ids[i]   = slot_ids[i + 1];
                slot_times[i] = slot_times[i + 1];
            end
            held--;
        endfunction

        function int find_front(logic [ID_W-1:0] id);
            int i;
            for (i = 0; i < held; i++)
                if (slot_ids[i] == id)
                    return i;
            return -1;
        endfunction

        // Apply one accepted request and queue the reply it must produce
        function void predict_request(srtfq_pkg::cmd_t c);
            srtfq_pkg::res_t r;
            int              i;
            int              pos;
            int              best;
            logic [ID_W-1:0] sel_id;
            logic [T_W-1:0]  sel_time;
            r = '0;
            case (c.action)
                srtfq_pkg::ACT_ADD:
                begin
                    if (c.remaining_time == '0)
                        r.expired_count = CNT_W'(1);
                    else if (held < DEPTH)
                    begin
                        slot_ids[held]   = c.proc_id;
                        slot_times[held] = c.remaining_time;
                        held++;
                        r.accepted = 1'b1;
                    end
                    else
                        full_rejects++;
                end
                srtfq_pkg::ACT_PICK:
                begin
                    // drop expired entries, then rotate the shortest to the front
                    i = 0;
                    while (i < held)
                    begin
                        if (slot_times[i] == '0)
                        begin
                            drop_at(i);
                            r.expired_count = r.expired_count + 1'b1;
                        end
                        else
                            i++;
                    end
                    if (held > 0)
                    begin
                        best = 0;
                        for (i = 1; i < held; i++)
                            if (slot_times[i] < slot_times[best])
                                best = i;
                        sel_id   = slot_ids[best];
                        sel_time = slot_times[best];
                        for (i = best; i > 0; i--)
                        begin
                            slot_ids[i]   = slot_ids[i - 1];
                            slot_times[i] = slot_times[i - 1];
                        end
                        slot_ids[0]    = sel_id;
                        slot_times[0]  = sel_time;
                        r.chosen_valid = 1'b1;
                        r.chosen_id    = sel_id;
                        picks_made++;
                    end
                end
                srtfq_pkg::ACT_REMOVE:
                begin
                    pos = find_front(c.proc_id);
                    if (pos >= 0)
                    begin
                        drop_at(pos);
                        r.accepted = 1'b1;
                    end
                end
                default:
                begin
                    pos = find_front(c.proc_id);
                    if (pos >= 0)
                    begin
                        slot_times[pos] = c.remaining_time;
                        r.accepted = 1'b1;
                    end
                end
            endcase
            expired_seen += int'(r.expired_count);
            r.queue_count = held[CNT_W-1:0];
            pending_replies = {pending_replies, r};
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one reply against the oldest forecast
        function void check_reply(logic [OUT_W-1:0] data);
            srtfq_pkg::res_t got;
            srtfq_pkg::res_t want;
            got = srtfq_pkg::res_t'(data[RES_W-1:0]);
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, got 0x%06h", $time, data);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            replies_checked++;
            compare_field("accepted", int'(want.accepted), int'(got.accepted));
            compare_field("chosen_valid", int'(want.chosen_valid), int'(got.chosen_valid));
            compare_field("chosen_id", int'(want.chosen_id), int'(got.chosen_id));
            compare_field("expired_count", int'(want.expired_count),
                          int'(got.expired_count));
            compare_field("queue_count", int'(want.queue_count), int'(got.queue_count));
            compare_field("padding", 0, int'(data[OUT_W-1:RES_W]));
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_valid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_data;
    logic             m_axis_tvalid;
    logic             m_ready;
    logic [OUT_W-1:0] m_axis_tdata;

    ready_list_model model;
    bit              idle_en;
    bit              hold_req;
    int              stall_left;
    int              long_holds;
    int              items_sent;
    int              cycles;

    srtf_ready_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic srtfq_pkg::cmd_t make_cmd(srtfq_pkg::action_t a, logic [ID_W-1:0] id,
                                                 logic [T_W-1:0] t);
        srtfq_pkg::cmd_t c;
        c.action         = a;
        c.proc_id        = id;
        c.remaining_time = t;
        return c;
    endfunction

    // Times lean toward zero, small values for ties, and the top of the range
    function automatic logic [T_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return '0;
        else if (r < 40)
            return T_W'($urandom_range(1, 4));
        else if (r < 50)
            return {T_W{1'b1}};
        return T_W'($urandom_range(1, (1 << T_W) - 1));
    endfunction

    // Prefer ids that are on the list so remove and update hit
    function automatic logic [ID_W-1:0] pick_id();
        if (model.held > 0 && $urandom_range(0, 99) < 70)
            return model.slot_ids[$urandom_range(0, model.held - 1)];
        return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    endfunction

    // Offer one request and hold it until transfer
    task automatic send_cmd(input srtfq_pkg::cmd_t c);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 1) == 1)
            gap = gap_len();
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(IN_W - CMD_W){1'b0}}, c};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Stop offering, wait for every reply, resume at a falling edge
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (model.pending_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, forced long hold-off on request
    initial
    begin
        m_ready    = 1'b0;
        stall_left = 0;
        long_holds = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD - 1;
                long_holds++;
                m_ready <= 1'b0;
            end
            else if (!idle_en || $urandom_range(0, 99) < 70)
                m_ready <= 1'b1;
            else
            begin
                stall_left = gap_len() - 1;
                m_ready <= 1'b0;
            end
        end
    end

    // Monitor both transfers at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_ready)
                model.check_reply(m_axis_tdata);
            if (s_valid && s_axis_tready)
                model.predict_request(srtfq_pkg::cmd_t'(s_data[CMD_W-1:0]));
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d replies outstanding",
                     cycles, model.pending_replies.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int              i;
        int              k;
        int              n;
        int              kind;
        int              base;
        bit              held_off;
        bit              paused;
        logic [ID_W-1:0] snap [DEPTH];

        model      = new();
        rst_n      = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        items_sent = 0;
        cycles     = 0;
        held_off   = 1'b0;
        paused     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty list, misses, zero time, extremes, ties, duplicates, full list
        send_cmd(make_cmd(srtfq_pkg::ACT_PICK, 8'd0, 20'd0));
        send_cmd(make_cmd(srtfq_pkg::ACT_REMOVE, 8'd5, 20'd0));
        send_cmd(make_cmd(srtfq_pkg::ACT_UPDATE, 8'd5, 20'd9));
        send_cmd(make_cmd(srtfq_pkg::ACT_ADD, 8'd0, 20'd0));
        send_cmd(make_cmd(srtfq_pkg::ACT_ADD, 8'hFF, 20'hFFFFF));
        send_cmd(make_cmd(srtfq_pkg::ACT_ADD, 8'hAA, 20'd5));
        send_cmd(make_cmd(srtfq_pkg::ACT_ADD, 8'h55, 20'd5));
        send_cmd(make_cmd(srtfq_pkg::ACT_ADD, 8'hAA, 20'd3));
        send_cmd(make_cmd(srtfq_pkg::ACT_PICK, 8'd0, 20'd0));
        send_cmd(make_cmd(srtfq_pkg::ACT_UPDATE, 8'hAA, 20'd0));
        send_cmd(make_cmd(srtfq_pkg::ACT_PICK, 8'd0, 20'd0));
        send_cmd(make_cmd(srtfq_pkg::ACT_REMOVE, 8'hAA, 20'd0));
        for (i = 0; i < 13; i++)
            send_cmd(make_cmd(srtfq_pkg::ACT_ADD, 8'(i + 16), 20'd7));
        send_cmd(make_cmd(srtfq_pkg::ACT_ADD, 8'h33, 20'd1));
        wait_drained();

        // Clear the list, then force every entry to expire at once
        n = model.held;
        for (k = 0; k < n; k++)
            snap[k] = model.slot_ids[k];
        for (k = 0; k < n; k++)
            send_cmd(make_cmd(srtfq_pkg::ACT_REMOVE, snap[k], 20'd0));
        send_cmd(make_cmd(srtfq_pkg::ACT_ADD, 8'h01, 20'd2));
        send_cmd(make_cmd(srtfq_pkg::ACT_ADD, 8'h02, 20'd2));
        send_cmd(make_cmd(srtfq_pkg::ACT_UPDATE, 8'h01, 20'd0));
        send_cmd(make_cmd(srtfq_pkg::ACT_UPDATE, 8'h02, 20'd0));
        send_cmd(make_cmd(srtfq_pkg::ACT_PICK, 8'd0, 20'd0));

        // Random traffic: mostly meaningful list operations, some noise
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if (!held_off && items_sent - base > 250)
            begin
                held_off = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && items_sent - base > 450)
            begin
                paused = 1'b1;
                wait_drained();
                idle_en = 1'b0;
            end
            if (paused && items_sent - base > 650)
                idle_en = 1'b1;

            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                n = (model.held > 10) ? $urandom_range(1, 2) : $urandom_range(1, 5);
                for (k = 0; k < n; k++)
                    send_cmd(make_cmd(srtfq_pkg::ACT_ADD, pick_id(), pick_time()));
            end
            else if (kind < 55)
                send_cmd(make_cmd(srtfq_pkg::ACT_PICK, ID_W'($urandom_range(0, 255)),
                                  pick_time()));
            else if (kind < 67)
            begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    send_cmd(make_cmd(srtfq_pkg::ACT_REMOVE, pick_id(), pick_time()));
            end
            else if (kind < 82)
                send_cmd(make_cmd(srtfq_pkg::ACT_UPDATE, pick_id(), pick_time()));
            else if (kind < 88)
            begin
                // expire every held entry, then pick
                n = model.held;
                for (k = 0; k < n; k++)
                    snap[k] = model.slot_ids[k];
                for (k = 0; k < n; k++)
                    send_cmd(make_cmd(srtfq_pkg::ACT_UPDATE, snap[k], 20'd0));
                send_cmd(make_cmd(srtfq_pkg::ACT_PICK, 8'd0, 20'd0));
            end
            else
                send_cmd(srtfq_pkg::cmd_t'(CMD_W'($urandom_range(0, (1 << CMD_W) - 1))));
        end

        // Drain and let the block settle
        wait_drained();
        repeat (60) @(posedge clk);

        $display("Covered %0d requests, %0d replies checked, %0d picks with a choice,",
                 items_sent, model.replies_checked, model.picks_made);
        $display("%0d entries expired, %0d adds rejected on a full list, %0d long hold-offs",
                 model.expired_seen, model.full_rejects, long_holds);
        if (model.errors == 0 && model.pending_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
